>>> rtl/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg: shared types and constants for the integer to radix text block
// Item formats for both channels, field widths and the digit to ASCII map.
// ----------------------------------------------------------------------------
package itr_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_BITS = 6;
    localparam int DIGIT_BITS = 6;
    localparam int CODE_BITS  = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_DECIMAL = 6'd10;

    localparam logic [CODE_BITS-1:0] CODE_MINUS  = 7'd45;
    localparam logic [CODE_BITS-1:0] CODE_ZERO   = 7'd48;
    localparam logic [CODE_BITS-1:0] CODE_LETTER = 7'd55;  // 'A' minus ten
    localparam logic [CODE_BITS-1:0] CODE_NONE   = 7'd0;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic        [RADIX_BITS-1:0] radix;
    } num_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] char_code;
        logic                 last;
        logic                 bad_radix;
    } chr_item_t;

    function automatic logic [CODE_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CODE_BITS-1:0] code;
        if (d < 6'd10)
            code = CODE_ZERO + {1'b0, d};
        else if (d < 6'd36)
            code = CODE_LETTER + {1'b0, d};
        else
            code = CODE_NONE;
        return code;
    endfunction

endpackage

>>> rtl/itr_divider.sv
// ----------------------------------------------------------------------------
// itr_divider: restoring divider by a small radix
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module itr_divider
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [itr_pkg::VALUE_BITS-1:0]     dividend,
    input  logic [itr_pkg::RADIX_BITS-1:0]     divisor,
    output logic                               done,
    output logic [itr_pkg::VALUE_BITS-1:0]     quotient,
    output logic [itr_pkg::DIGIT_BITS-1:0]     remainder
);

    localparam int CNT_W = $clog2(itr_pkg::VALUE_BITS + 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [itr_pkg::VALUE_BITS-1:0]    quo_reg;
    logic [itr_pkg::DIGIT_BITS-1:0]    rem_reg;
    logic [itr_pkg::RADIX_BITS-1:0]    dvs_reg;

    logic [itr_pkg::DIGIT_BITS:0]      trial;
    logic [itr_pkg::DIGIT_BITS:0]      diff;
    logic                              fits;

    // The remainder stays below the divisor, so one extra bit holds the trial.
    assign trial = {rem_reg, quo_reg[itr_pkg::VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(itr_pkg::VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[itr_pkg::VALUE_BITS-2:0], fits};
            rem_reg <= fits ? diff[itr_pkg::DIGIT_BITS-1:0] : trial[itr_pkg::DIGIT_BITS-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text: signed integer to ASCII text in radix 2 to 36
// Converts one number per item and sends its characters most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   The num channel takes an item with a signed value and a radix. The chr
//   channel returns one item per character, most significant first, with last
//   set on the final one. A minus sign leads only for negative values in radix
//   10; other radixes read the value as unsigned two's complement. A radix
//   outside 2..36 yields a single item with bad_radix and last set, code zero.
//   Digits are found one at a time by a shared restoring divider; they are
//   stored least significant first and read back in reverse through a
//   registered memory port. Each digit character passes through a read, a
//   load and an output state; a minus sign goes straight to the output state.
//   num_ready is high only while the block is idle. A stalled receiver holds
//   the current character in the output register and the block waits.
//   Reset returns the sequencer to idle with no item pending.
// ----------------------------------------------------------------------------
module integer_to_radix_text
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  itr_pkg::num_item_t  num_data,
    output logic                chr_valid,
    input  logic                chr_ready,
    output itr_pkg::chr_item_t  chr_data
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_READ = 5'b00100,
        ST_LOAD = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                             state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic                               neg_reg, neg_next;
    logic [itr_pkg::RADIX_BITS-1:0]     radix_reg, radix_next;
    itr_pkg::chr_item_t                 out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;

    logic [itr_pkg::DIGIT_BITS-1:0]     digit_store [MAX_DIGITS];
    logic [itr_pkg::DIGIT_BITS-1:0]     rd_data_reg;
    logic [AW-1:0]                      rd_addr;
    logic                               wr_en;

    logic                               div_start;
    logic                               div_done;
    logic [itr_pkg::VALUE_BITS-1:0]     div_dividend;
    logic [itr_pkg::RADIX_BITS-1:0]     div_divisor;
    logic [itr_pkg::VALUE_BITS-1:0]     div_quot;
    logic [itr_pkg::DIGIT_BITS-1:0]     div_rem;

    logic                               accept;
    logic                               radix_bad;
    logic                               in_neg;
    logic [itr_pkg::VALUE_BITS-1:0]     in_mag;
    logic [CW-1:0]                      limit;

    itr_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign accept    = num_valid && num_ready;
    assign radix_bad = (num_data.radix < itr_pkg::RADIX_MIN)
                    || (num_data.radix > itr_pkg::RADIX_MAX);
    assign in_neg    = (num_data.radix == itr_pkg::RADIX_DECIMAL)
                    && num_data.value[itr_pkg::VALUE_BITS-1];
    // Negating the most negative value gives its magnitude as an unsigned word.
    assign in_mag    = in_neg ? (~num_data.value + itr_pkg::VALUE_BITS'(1)) : num_data.value;

    assign limit   = CW'(MAX_DIGITS) - CW'(neg_reg);
    assign rd_addr = AW'(count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        div_dividend   = div_quot;
        div_divisor    = radix_reg;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = in_mag;
                div_divisor  = num_data.radix;
                if (accept)
                begin
                    if (radix_bad)
                    begin
                        out_next       = '{char_code: itr_pkg::CODE_NONE, last: 1'b1,
                                           bad_radix: 1'b1};
                        out_valid_next = 1'b1;
                        neg_next       = 1'b0;
                        count_next     = '0;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        neg_next   = in_neg;
                        radix_next = num_data.radix;
                        count_next = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // Digits past the limit are dropped; only the count saturates.
                    if (count_reg < limit)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (div_quot != '0)
                        div_start = 1'b1;
                    else if (neg_reg)
                    begin
                        out_next       = '{char_code: itr_pkg::CODE_MINUS, last: 1'b0,
                                           bad_radix: 1'b0};
                        out_valid_next = 1'b1;
                        neg_next       = 1'b0;
                        state_next     = ST_OUT;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                out_next       = '{char_code: itr_pkg::digit_char(rd_data_reg),
                                   last: (count_reg == CW'(1)), bad_radix: 1'b0};
                out_valid_next = 1'b1;
                count_next     = count_reg - CW'(1);
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (chr_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_reg.last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_store[count_reg[AW-1:0]] <= div_rem;
        if (state_reg == ST_READ)
            rd_data_reg <= digit_store[rd_addr];
    end

    assign num_ready = (state_reg == ST_IDLE);
    assign chr_valid = out_valid_reg;
    assign chr_data  = out_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid |-> !num_ready)
        else $error("input accepted while a character is pending");

    a_bad_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (num_valid && num_ready && (num_data.radix < itr_pkg::RADIX_MIN
                                    || num_data.radix > itr_pkg::RADIX_MAX))
        |=> (chr_valid && chr_data.bad_radix && chr_data.last))
        else $error("bad radix did not yield a single flagged item");

    a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
        (chr_valid && chr_data.bad_radix) |-> (chr_data.char_code == itr_pkg::CODE_NONE))
        else $error("flagged item carries a character code");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (count_reg != '0))
        else $error("digit read with no digits held");

endmodule
